// ----- src/fuls_pkg.sv -----
`timescale 1ns / 1ps
// Package for the first-unique-letter stream unit.
// Holds the word types, the field widths and the control/status structs; no dependencies.
package fuls_pkg;

  // Width of a letter index on the ports.
  localparam int LETTER_W = 5;

  // Count codes held per letter.
  localparam logic [1:0] CNT_ONCE = 2'd1;
  localparam logic [1:0] CNT_MANY = 2'd2;

  // Input word: start flag and letter index.
  typedef struct packed {
    logic                start_new;
    logic [LETTER_W-1:0] letter;
  } in_word_t;

  // Result word: found flag and earliest unique letter.
  typedef struct packed {
    logic                found;
    logic [LETTER_W-1:0] unique_letter;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word, clear on start
    logic update;    // update count and arrival queue
    logic ord_rd;    // read the queue entry at the head
    logic cnt_rd;    // read the count of the head letter
    logic head_inc;  // skip the head entry
    logic push;      // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic queue_nonempty;
    logic head_repeat;
    logic out_free;
  } sts_t;

endpackage

// ----- src/fuls_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module fuls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/fuls_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the first-unique-letter stream unit: count and arrival memories,
// head and tail pointers, and the result register. Depends on fuls_pkg and fuls_ram.
module fuls_dp
  import fuls_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_word_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_word_t out_data
);

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam int PTR_W = $clog2(ALPHABET_SIZE + 1);

  in_word_t            word_r;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [ALPHABET_SIZE-1:0] seen_r, seen_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  logic [IDX_W-1:0]    letter_idx;
  logic [IDX_W-1:0]    head_idx;
  logic [IDX_W-1:0]    cnt_raddr;
  logic                in_range;
  logic                first_time;
  logic                cnt_we;
  logic [1:0]          cnt_wdata;
  logic [1:0]          cnt_q;
  logic                ord_we;
  logic [LETTER_W-1:0] ord_q;
  logic [IDX_W-1:0]    ord_idx;

  assign letter_idx = IDX_W'(word_r.letter);
  assign head_idx   = head_r[IDX_W-1:0];
  assign ord_idx    = IDX_W'(ord_q);
  assign in_range   = 32'(word_r.letter) < 32'(ALPHABET_SIZE);
  // A letter that has no seen bit has a count of zero.
  assign first_time = in_range && !seen_r[letter_idx];

  // Count reads go at the incoming letter, or at the letter under the head.
  assign cnt_raddr = cmd.load ? IDX_W'(in_data.letter) : ord_idx;
  assign cnt_we    = cmd.update && in_range;
  assign cnt_wdata = first_time ? CNT_ONCE : CNT_MANY;
  assign ord_we    = cmd.update && first_time && (32'(tail_r) < 32'(ALPHABET_SIZE));

  fuls_ram #(
    .WIDTH (2),
    .DEPTH (ALPHABET_SIZE)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (letter_idx),
    .wdata (cnt_wdata),
    .re    (cmd.load || cmd.cnt_rd),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  fuls_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (tail_r[IDX_W-1:0]),
    .wdata (word_r.letter),
    .re    (cmd.ord_rd),
    .raddr (head_idx),
    .rdata (ord_q)
  );

  // Pointer, seen-bit and result register updates.
  always_comb begin
    tail_nxt      = tail_r;
    head_nxt      = head_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.load && in_data.start_new) begin
      tail_nxt = '0;
      head_nxt = '0;
      seen_nxt = '0;
    end
    if (cmd.update && in_range) begin
      seen_nxt[letter_idx] = 1'b1;
    end
    if (ord_we) begin
      tail_nxt = tail_r + PTR_W'(1);
    end
    if (cmd.head_inc) begin
      head_nxt = head_r + PTR_W'(1);
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.push) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.found         = sts.queue_nonempty;
      out_data_nxt.unique_letter = sts.queue_nonempty ? ord_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r      <= '0;
      head_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tail_r      <= tail_nxt;
      head_r      <= head_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  // Status back to the controller.
  assign sts.queue_nonempty = head_r < tail_r;
  assign sts.head_repeat    = seen_r[ord_idx] && cnt_q[1];
  assign sts.out_free       = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/fuls_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the first-unique-letter stream unit: sequences the update and the head scan.
// Depends on fuls_pkg.
module fuls_ctrl
  import fuls_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_ORD_WAIT,
    S_CNT_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (sts.queue_nonempty) begin
          cmd.ord_rd = 1'b1;
          state_nxt  = S_ORD_WAIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ORD_WAIT: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_CNT_WAIT;
      end
      S_CNT_WAIT: begin
        // A repeated letter at the head can never qualify again.
        if (sts.head_repeat) begin
          cmd.head_inc = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/first_unique_letter_stream_unit.sv -----
`timescale 1ns / 1ps
// Top level of the first-unique-letter stream unit. Depends on fuls_pkg, fuls_ctrl, fuls_dp.
//
// Each input word carries a letter index and a start flag that empties the current sequence
// before the letter is taken. For every word the unit returns one result word: the earliest
// letter of the sequence seen exactly once so far, or found low with a letter of zero. Letters
// at or above ALPHABET_SIZE are ignored but still produce a result. An accepted word passes
// through S_UPD and S_SCAN; when the arrival queue is not empty, S_ORD_WAIT and S_CNT_WAIT
// read the head entry and its count, and S_DONE loads the result register once it is free.
// Every repeated letter skipped at the head adds another pass through S_SCAN, S_ORD_WAIT and
// S_CNT_WAIT. The skip loop runs through the single read port of the arrival memory and then
// the count memory. The next word is taken in S_IDLE, after the result is loaded. Skips never
// exceed ALPHABET_SIZE over a whole sequence. The result register lets a new word be accepted
// while the previous result waits to be taken. No clearing pass is needed after reset.
module first_unique_letter_stream_unit
  import fuls_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  fuls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and result register.
  fuls_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- sim/first_unique_letter_stream_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for first_unique_letter_stream_unit: drives letter words, predicts each result word.
// Depends on fuls_pkg and the unit itself; results are checked in order against a scoreboard.
module first_unique_letter_stream_unit_tb;
  import fuls_pkg::*;

  localparam int ALPHA = 26;
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 500;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // Idling controls shared by the driver and the sink.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned holds_done = 0;

  // Tracks the stream state and holds the answers still owed by the unit.
  class unique_letter_board;
    logic [1:0]          seen_count [ALPHA];
    logic [LETTER_W-1:0] first_order [ALPHA];
    int unsigned         order_tail;
    int unsigned         order_head;
    out_word_t           owed_answers [$];
    int unsigned         mismatches;
    int unsigned         words_taken;
    int unsigned         answers_seen;

    function new();
      clear_sequence();
      mismatches = 0;
      words_taken = 0;
      answers_seen = 0;
    endfunction

    function void clear_sequence();
      foreach (seen_count[i]) seen_count[i] = CNT_NONE;
      order_tail = 0;
      order_head = 0;
    endfunction

    // Update the counts and arrival order, then skip repeated letters at the head.
    function out_word_t first_unique_after(in_word_t w);
      out_word_t   ans;
      int unsigned ch;
      if (w.start_new) clear_sequence();
      ch = w.letter;
      if (ch < ALPHA) begin
        if (seen_count[ch] == CNT_NONE) begin
          if (order_tail < ALPHA) begin
            first_order[order_tail] = w.letter;
            order_tail++;
          end
          seen_count[ch] = CNT_ONCE;
        end else begin
          seen_count[ch] = CNT_MANY;
        end
      end
      while (order_head < order_tail && seen_count[first_order[order_head]] == CNT_MANY)
        order_head++;
      ans.found = (order_head < order_tail);
      ans.unique_letter = ans.found ? first_order[order_head] : '0;
      return ans;
    endfunction

    function void note_word(in_word_t w);
      owed_answers.push_back(first_unique_after(w));
      words_taken++;
    endfunction

    function void check_answer(out_word_t got);
      out_word_t want;
      answers_seen++;
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual found=%0d letter=%0d",
                 $time, got.found, got.unique_letter);
        mismatches++;
        return;
      end
      want = owed_answers.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0d, actual %0d", $time, want.found, got.found);
        mismatches++;
      end
      if (got.unique_letter !== want.unique_letter) begin
        $display("%0t: unique_letter mismatch, expected %0d, actual %0d",
                 $time, want.unique_letter, got.unique_letter);
        mismatches++;
      end
    endfunction
  endclass

  unique_letter_board board;

  first_unique_letter_stream_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one word, after a random gap, and wait until the unit takes it.
  task automatic send_word(input logic start_new, input logic [LETTER_W-1:0] letter);
    in_word_t    w;
    int unsigned gap;
    gap = 0;
    w.start_new = start_new;
    w.letter = letter;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(w);
  endtask

  // Stop offering words until every owed answer has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.owed_answers.size() != 0) @(posedge clk);
  endtask

  // Hand-picked words covering the edges of the letter field and the skip logic.
  task automatic run_directed();
    // The stream begins without a start flag.
    send_word(1'b0, 5'd0);
    send_word(1'b0, 5'd1);
    send_word(1'b0, 5'd0);
    // A third occurrence saturates the count.
    send_word(1'b0, 5'd0);
    send_word(1'b0, 5'd1);
    // Letters outside the alphabet are ignored but still answered.
    send_word(1'b0, 5'd31);
    send_word(1'b0, 5'd26);
    send_word(1'b0, 5'd25);
    send_word(1'b1, 5'd25);
    send_word(1'b0, 5'd25);
    // A start flag with an ignored letter leaves an empty sequence.
    send_word(1'b1, 5'd31);
    send_word(1'b0, 5'd16);
    // Several repeated letters are skipped at the head at once.
    send_word(1'b1, 5'd0);
    send_word(1'b0, 5'd1);
    send_word(1'b0, 5'd2);
    send_word(1'b0, 5'd3);
    send_word(1'b0, 5'd1);
    send_word(1'b0, 5'd2);
    send_word(1'b0, 5'd0);
    send_word(1'b0, 5'd3);
    send_word(1'b1, 5'd15);
    send_word(1'b0, 5'd30);
  endtask

  // Random sequences: mostly well formed, with stray letters and broken starts mixed in.
  task automatic run_random(input int unsigned quota, input bit with_hold, input bit with_pause);
    int unsigned counted;
    int unsigned seq_len;
    int unsigned pool;
    int unsigned base;
    int unsigned i;
    logic        start_new;
    logic [LETTER_W-1:0] letter;
    bit          hold_sent;
    bit          pause_done;
    counted = 0;
    hold_sent = 0;
    pause_done = 0;
    while (counted < quota) begin
      seq_len = ($urandom_range(9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
      pool = ($urandom_range(3) == 0) ? ALPHA : $urandom_range(1, 10);
      base = $urandom_range(ALPHA - 1);
      for (i = 0; i < seq_len; i++) begin
        start_new = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(39) == 0);
        if ($urandom_range(24) == 0) begin
          letter = LETTER_W'($urandom_range(ALPHA, 31));
        end else begin
          letter = LETTER_W'((base + $urandom_range(pool - 1)) % ALPHA);
          counted++;
        end
        send_word(start_new, letter);
        if (with_hold && !hold_sent && counted >= quota / 2) begin
          hold_request = HOLD_CYCLES;
          hold_sent = 1;
        end
        if (with_pause && !pause_done && counted >= quota / 2) begin
          wait_for_drain();
          pause_done = 1;
        end
      end
    end
  endtask

  // Result sink: takes results, stalls at random, and runs long hold-offs on request.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) board.check_answer(out_data);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Main sequence: reset, directed words, then four idling phases.
  initial begin : stimulus
    board = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_for_drain();

    // No idling on either side.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b0);
    wait_for_drain();

    // Sender mostly idle, with one pause until the unit is empty.
    send_idle_pct = 71;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b1);
    wait_for_drain();

    // Receiver mostly stalling, plus a long hold-off that backs up the input.
    send_idle_pct = 0;
    recv_stall_pct = 71;
    run_random(RANDOM_PER_PHASE, 1'b1, 1'b0);
    wait_for_drain();

    // Both sides idling now and then.
    send_idle_pct = 20;
    recv_stall_pct = 20;
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b0);
    wait_for_drain();

    repeat (100) @(posedge clk);

    $display("Run covered %0d words and %0d result words over four idling phases,",
             board.words_taken, board.answers_seen);
    $display("with %0d long receiver hold-off(s) and sender pauses until empty.", holds_done);
    if (board.mismatches == 0 && board.owed_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a unit that stops answering.
  initial begin : watchdog
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
